// File: rtl/swbb_pkg.sv
// shared types, constants and helpers for the shape world bounding box block
// no dependencies
`default_nettype none
package swbb_pkg;
  localparam int unsigned QuatFracBits = 14;
  localparam int unsigned QuatW = 16;
  localparam int unsigned CoordW = 32;
  localparam int unsigned SizeW = 31;
  // matrix entry magnitude after rounding: |m| < 2^(2*16+2), shifted by F
  localparam int unsigned MagW = 2 * QuatW + 3 - QuatFracBits;
  localparam int unsigned ProdW = MagW + SizeW;
  localparam int unsigned SumW = ProdW + 2;
  localparam int unsigned ExtW = SumW - QuatFracBits + 1;

  typedef enum logic [1:0] {
    KindSphere  = 2'd0,
    KindCapsule = 2'd1,
    KindBox     = 2'd2,
    KindNone    = 2'd3
  } shape_kind_e;

  typedef struct packed {
    logic [1:0]               shape_kind;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [QuatW-1:0]  quat_w;
    logic signed [QuatW-1:0]  quat_x;
    logic signed [QuatW-1:0]  quat_y;
    logic signed [QuatW-1:0]  quat_z;
    logic [SizeW-1:0]         size_a;
    logic [SizeW-1:0]         size_b;
    logic [SizeW-1:0]         size_c;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
  } out_item_t;

  function automatic logic [CoordW-1:0] sat_coord(input logic signed [ExtW+1:0] v);
    logic signed [ExtW+1:0] hi;
    logic signed [ExtW+1:0] lo;
    hi = (ExtW+2)'(signed'({1'b0, {(CoordW-1){1'b1}}}));
    lo = -hi - (ExtW+2)'(1);
    if (v > hi) sat_coord = hi[CoordW-1:0];
    else if (v < lo) sat_coord = lo[CoordW-1:0];
    else sat_coord = v[CoordW-1:0];
  endfunction
endpackage
`default_nettype wire

// File: rtl/swbb_stream_if.sv
// valid/ready channel carrying one item payload
// depends on nothing but its type parameter
`default_nettype none
interface swbb_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/swbb_matrix.sv
// stages 1-2: quaternion products, then rotation matrix magnitudes rounded
// depends on swbb_pkg
`default_nettype none
module swbb_matrix (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire swbb_pkg::in_item_t            item_i,
  output swbb_pkg::in_item_t                 item_o,
  output logic [8:0][swbb_pkg::MagW-1:0]     mag_o
);
  import swbb_pkg::*;
  localparam int unsigned PW = 2 * QuatW;
  localparam int unsigned MW = PW + 3;

  in_item_t item1_q, item2_q;
  logic signed [PW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [MW-1:0] m_d [9];
  logic [8:0][MagW-1:0] mag_d, mag_q;
  logic signed [MW-1:0] one;

  assign one = MW'(1) <<< (2 * QuatFracBits);

  always_comb begin
    m_d[0] = one - 2 * (MW'(yy_q) + MW'(zz_q));
    m_d[1] = 2 * (MW'(xy_q) - MW'(wz_q));
    m_d[2] = 2 * (MW'(xz_q) + MW'(wy_q));
    m_d[3] = 2 * (MW'(xy_q) + MW'(wz_q));
    m_d[4] = one - 2 * (MW'(xx_q) + MW'(zz_q));
    m_d[5] = 2 * (MW'(yz_q) - MW'(wx_q));
    m_d[6] = 2 * (MW'(xz_q) - MW'(wy_q));
    m_d[7] = 2 * (MW'(yz_q) + MW'(wx_q));
    m_d[8] = one - 2 * (MW'(xx_q) + MW'(yy_q));
    for (int k = 0; k < 9; k++) begin
      logic [MW:0] a;
      a = m_d[k][MW-1] ? (MW+1)'(-m_d[k]) : (MW+1)'(m_d[k]);
      a = a + (MW+1)'(1 << (QuatFracBits - 1));
      mag_d[k] = MagW'(a >> QuatFracBits);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item1_q <= item_i;
      xx_q <= item_i.quat_x * item_i.quat_x;
      yy_q <= item_i.quat_y * item_i.quat_y;
      zz_q <= item_i.quat_z * item_i.quat_z;
      xy_q <= item_i.quat_x * item_i.quat_y;
      xz_q <= item_i.quat_x * item_i.quat_z;
      yz_q <= item_i.quat_y * item_i.quat_z;
      wx_q <= item_i.quat_w * item_i.quat_x;
      wy_q <= item_i.quat_w * item_i.quat_y;
      wz_q <= item_i.quat_w * item_i.quat_z;
      item2_q <= item1_q;
      mag_q <= mag_d;
    end
  end

  assign item_o = item2_q;
  assign mag_o = mag_q;
endmodule
`default_nettype wire

// File: rtl/swbb_extent.sv
// stages 3-4: magnitude times size products, then summed, rounded world extents
// depends on swbb_pkg
`default_nettype none
module swbb_extent (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire swbb_pkg::in_item_t            item_i,
  input  wire logic [8:0][swbb_pkg::MagW-1:0] mag_i,
  output swbb_pkg::in_item_t                 item_o,
  output logic [2:0][swbb_pkg::ExtW-1:0]     ext_o
);
  import swbb_pkg::*;

  in_item_t item3_q, item4_q;
  logic [8:0][ProdW-1:0] prod_q;
  logic [2:0][ExtW-1:0] ext_d, ext_q;
  logic [SizeW-1:0] h [3];

  assign h[0] = item_i.size_a;
  assign h[1] = item_i.size_b;
  assign h[2] = item_i.size_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [SumW-1:0] s;
      logic [SumW-1:0] c;
      c = SumW'(prod_q[3*i+1]) + SumW'(1 << (QuatFracBits - 1));
      s = SumW'(prod_q[3*i]) + SumW'(prod_q[3*i+1]) + SumW'(prod_q[3*i+2])
        + SumW'(1 << (QuatFracBits - 1));
      case (shape_kind_e'(item3_q.shape_kind))
        KindSphere:  ext_d[i] = ExtW'(item3_q.size_a);
        KindCapsule: ext_d[i] = ExtW'(c >> QuatFracBits) + ExtW'(item3_q.size_a);
        KindBox:     ext_d[i] = ExtW'(s >> QuatFracBits);
        default:     ext_d[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item3_q <= item_i;
      for (int k = 0; k < 9; k++) prod_q[k] <= ProdW'(mag_i[k]) * ProdW'(h[k % 3]);
      item4_q <= item3_q;
      ext_q <= ext_d;
    end
  end

  assign item_o = item4_q;
  assign ext_o = ext_q;
endmodule
`default_nettype wire

// File: rtl/shape_world_bounding_box_core.sv
// One item per cycle sustained while the output side keeps taking results.
// Five register stages (products, matrix, size products, extents, corners); the
// whole pipeline advances when the output register is free or being taken.
// Reset clears stage valid bits only; payload registers are not reset.
// depends on swbb_pkg, swbb_stream_if, swbb_matrix, swbb_extent
`default_nettype none
module shape_world_bounding_box_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  swbb_stream_if.sink   in_i,
  swbb_stream_if.source out_o
);
  import swbb_pkg::*;

  logic [4:0] vld_q;
  logic       en;
  in_item_t   item_m, item_e;
  logic [8:0][MagW-1:0] mag;
  logic [2:0][ExtW-1:0] ext;
  out_item_t  res_d, res_q;

  assign en = !vld_q[4] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], in_i.valid};
    end
  end

  swbb_matrix u_matrix (
    .clk_i, .en_i(en), .item_i(in_i.data), .item_o(item_m), .mag_o(mag)
  );
  swbb_extent u_extent (
    .clk_i, .en_i(en), .item_i(item_m), .mag_i(mag), .item_o(item_e), .ext_o(ext)
  );

  always_comb begin
    logic signed [ExtW+1:0] px, py, pz, ex, ey, ez;
    px = (ExtW+2)'(item_e.pos_x);
    py = (ExtW+2)'(item_e.pos_y);
    pz = (ExtW+2)'(item_e.pos_z);
    ex = (ExtW+2)'(ext[0]);
    ey = (ExtW+2)'(ext[1]);
    ez = (ExtW+2)'(ext[2]);
    res_d.min_x = sat_coord(px - ex);
    res_d.min_y = sat_coord(py - ey);
    res_d.min_z = sat_coord(pz - ez);
    res_d.max_x = sat_coord(px + ex);
    res_d.max_y = sat_coord(py + ey);
    res_d.max_z = sat_coord(pz + ez);
  end

  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_d;
  end

  assign out_o.valid = vld_q[4];
  assign out_o.data = res_q;
endmodule
`default_nettype wire

// File: rtl/swbb_checker.sv
// port-level checks for the bounding box core, attached by bind
// depends on swbb_pkg
`default_nettype none
module swbb_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire swbb_pkg::out_item_t out_data
);
  import swbb_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled item changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.min_x <= out_data.max_x && out_data.min_y <= out_data.max_y
      && out_data.min_z <= out_data.max_z)
    else $error("min above max");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
endmodule

bind shape_world_bounding_box_core swbb_checker u_swbb_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_data(out_o.data)
);
`default_nettype wire

// File: bench/tb_stream_if.sv
`timescale 1ns / 1ps
// testbench-side note: the channel interface lives with the rtl (swbb_stream_if)
// this file holds the item payload helper types used by the bench
// depends on swbb_pkg
package tb_shape_pkg;
  import swbb_pkg::*;
  typedef struct {
    in_item_t  pose;
    int        pause_after;
  } pending_pose_t;
endpackage

// File: bench/tb.sv
`timescale 1ns / 1ps
// bench for shape_world_bounding_box_core: drives posed shapes, predicts the world box
// with its own fixed-point model and checks every result in order
// depends on swbb_pkg, swbb_stream_if, tb_shape_pkg and the core
module tb;
  import swbb_pkg::*;
  import tb_shape_pkg::*;

  localparam int unsigned Frac = 14;
  localparam longint CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  swbb_stream_if #(.T(in_item_t))  pose_if ();
  swbb_stream_if #(.T(out_item_t)) box_if ();

  shape_world_bounding_box_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pose_if),
    .out_o  (box_if)
  );

  pending_pose_t pose_queue[$];
  out_item_t     box_expected[$];
  int            mismatches = 0;
  int            boxes_seen = 0;
  int            kind_count[4] = '{0, 0, 0, 0};
  int            sent = 0;
  longint        cycles = 0;
  bit            calm = 1'b0;
  int            hold_off = 0;

  function automatic longint unsigned round_mag(longint m);
    longint unsigned a;
    a = (m < 0) ? longint'(-m) : longint'(m);
    return (a + (64'd1 << (Frac - 1))) >> Frac;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic out_item_t world_box(in_item_t s);
    longint qw, qx, qy, qz, one, m[3][3], p[3];
    longint unsigned h[3], r[3][3], e[3], acc;
    out_item_t b;
    qw = s.quat_w; qx = s.quat_x; qy = s.quat_y; qz = s.quat_z;
    p[0] = s.pos_x; p[1] = s.pos_y; p[2] = s.pos_z;
    h[0] = s.size_a; h[1] = s.size_b; h[2] = s.size_c;
    one = 64'sd1 << (2 * Frac);
    m[0][0] = one - 2 * (qy * qy + qz * qz);
    m[0][1] = 2 * (qx * qy - qw * qz);
    m[0][2] = 2 * (qx * qz + qw * qy);
    m[1][0] = 2 * (qx * qy + qw * qz);
    m[1][1] = one - 2 * (qx * qx + qz * qz);
    m[1][2] = 2 * (qy * qz - qw * qx);
    m[2][0] = 2 * (qx * qz - qw * qy);
    m[2][1] = 2 * (qy * qz + qw * qx);
    m[2][2] = one - 2 * (qx * qx + qy * qy);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) r[i][j] = round_mag(m[i][j]);
    for (int i = 0; i < 3; i++) begin
      case (shape_kind_e'(s.shape_kind))
        KindSphere: e[i] = h[0];
        KindCapsule: e[i] = ((r[i][1] * h[1] + (64'd1 << (Frac - 1))) >> Frac) + h[0];
        KindBox: begin
          acc = r[i][0] * h[0] + r[i][1] * h[1] + r[i][2] * h[2];
          e[i] = (acc + (64'd1 << (Frac - 1))) >> Frac;
        end
        default: e[i] = 0;
      endcase
    end
    b.min_x = clamp32(p[0] - longint'(e[0]));
    b.min_y = clamp32(p[1] - longint'(e[1]));
    b.min_z = clamp32(p[2] - longint'(e[2]));
    b.max_x = clamp32(p[0] + longint'(e[0]));
    b.max_y = clamp32(p[1] + longint'(e[1]));
    b.max_z = clamp32(p[2] + longint'(e[2]));
    return b;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch box %0d %s: got %h want %h", boxes_seen, field, got, want);
  endtask

  function automatic logic [15:0] rand_quat_part();
    case ($urandom_range(0, 5))
      0: return 16'(-16384);
      1: return 16'd16384;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic [30:0] rand_size();
    case ($urandom_range(0, 5))
      0: return 31'h7fffffff;
      1: return 31'($urandom);
      2: return 31'd0;
      default: return 31'($urandom_range(0, 32'h00ff_ffff));
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_pose(logic [1:0] kind, logic [31:0] px, logic [31:0] py,
                          logic [31:0] pz, logic [15:0] w, logic [15:0] x,
                          logic [15:0] y, logic [15:0] z, logic [30:0] a,
                          logic [30:0] b, logic [30:0] c, int pause = 0);
    pending_pose_t pp;
    pp.pose = '{kind, px, py, pz, w, x, y, z, a, b, c};
    pp.pause_after = pause;
    pose_queue.push_back(pp);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_if.valid <= 1'b0;
      pose_if.data <= '0;
      hold_off <= 0;
    end else begin
      if (pose_if.valid && pose_if.ready) begin
        box_expected.push_back(world_box(pose_if.data));
        kind_count[pose_if.data.shape_kind]++;
        sent++;
      end
      if (pose_if.valid && !pose_if.ready) begin
      end else if (hold_off > 0 && box_expected.size() > 0) begin
        pose_if.valid <= 1'b0;
      end else if (pose_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 38)) begin
        pose_if.data <= pose_queue[0].pose;
        hold_off <= pose_queue[0].pause_after;
        pose_if.valid <= 1'b1;
        void'(pose_queue.pop_front());
      end else begin
        if (hold_off > 0) hold_off <= 0;
        pose_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_if.ready <= 1'b0;
    end else begin
      if (box_if.valid && box_if.ready) begin
        out_item_t want;
        out_item_t got;
        got = box_if.data;
        if (box_expected.size() == 0) begin
          mismatches++;
          $display("unexpected box at cycle %0d", cycles);
        end else begin
          want = box_expected.pop_front();
          if (got.min_x !== want.min_x) report("min_x", got.min_x, want.min_x);
          if (got.min_y !== want.min_y) report("min_y", got.min_y, want.min_y);
          if (got.min_z !== want.min_z) report("min_z", got.min_z, want.min_z);
          if (got.max_x !== want.max_x) report("max_x", got.max_x, want.max_x);
          if (got.max_y !== want.max_y) report("max_y", got.max_y, want.max_y);
          if (got.max_z !== want.max_z) report("max_z", got.max_z, want.max_z);
        end
        boxes_seen++;
      end
      box_if.ready <= calm || ($urandom_range(0, 99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d boxes pending", cycles, box_expected.size());
      $display("** shape_world_bounding_box_core: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [15:0] q[4];
    logic [1:0]  k;
    int          n;
    // directed: extremes, each kind, odd quaternions
    add_pose(KindSphere, 32'h7fffffff, 32'h80000000, 0, 16'd16384, 0, 0, 0,
             31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    add_pose(KindSphere, 32'h00010000, 32'hffff0000, 0, 16'd16384, 0, 0, 0, 31'h10000, 0, 0);
    add_pose(KindCapsule, 0, 0, 0, 16'd16384, 0, 0, 0, 31'h10000, 31'h20000, 31'h7fffffff);
    add_pose(KindCapsule, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'd11585, 16'd11585,
             0, 0, 31'h7fffffff, 31'h7fffffff, 0);
    add_pose(KindBox, 0, 0, 0, 16'd16384, 0, 0, 0, 31'h10000, 31'h20000, 31'h30000);
    add_pose(KindBox, 0, 0, 0, 16'd8192, 16'd8192, 16'd8192, 16'd8192,
             31'h10000, 31'h20000, 31'h30000);
    add_pose(KindBox, 32'h80000000, 32'h7fffffff, 0, 16'(-16384), 0, 0, 0,
             31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    add_pose(KindBox, 0, 0, 0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
             31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    add_pose(KindBox, 0, 0, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 0, 0);
    add_pose(KindNone, 32'h12345678, 32'h9abcdef0, 32'h7fffffff, 16'h7fff, 16'h8000,
             16'h1234, 16'hfedc, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 1);
    add_pose(KindNone, 32'hffffffff, 0, 32'h80000000, 0, 0, 0, 0, 0, 0, 0);
    // random part, quaternion parts mostly within +/-1.0 (Q1.14) with some raw bit patterns
    for (int i = 0; i < 650; i++) begin
      k = ($urandom_range(0, 9) == 0) ? KindNone : 2'($urandom_range(0, 2));
      for (int j = 0; j < 4; j++) q[j] = rand_quat_part();
      n = (i == 300) ? 1 : 0;
      add_pose(k, rand_pos(), rand_pos(), rand_pos(), q[0], q[1], q[2], q[3],
               rand_size(), rand_size(), rand_size(), n);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (sent > 200);
    @(posedge clk_i);
    calm <= 1'b1;
    wait (sent > 330);
    @(posedge clk_i);
    calm <= 1'b0;
    wait (pose_queue.size() == 0 && !pose_if.valid);
    wait (box_expected.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("covered %0d poses: %0d spheres, %0d capsules, %0d boxes, %0d unused kind",
             sent, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    $display("%0d boxes checked, %0d mismatches", boxes_seen, mismatches);
    if (mismatches == 0 && box_expected.size() == 0) begin
      $display("** shape_world_bounding_box_core: PASSED **");
    end else begin
      $display("** shape_world_bounding_box_core: FAILED **");
    end
    $finish;
  end
endmodule
